FILE: src/binary_to_decimal_ascii_defines.svh
// assertion macros shared by the converter rtl
// no dependencies; each file that asserts includes this header
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef ASSERT_OFF
// property that must hold on every clock edge out of reset
`define BDA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// same-cycle implication checked on every clock edge out of reset
`define BDA_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define BDA_ASSERT_ALWAYS(label, cond, msg)
`define BDA_ASSERT_IMPLY(label, pre, post, msg)
`endif
`endif

FILE: src/bda_pkg.sv
// types and constants of the binary to decimal ascii converter
// no dependencies; used by bda_cell and binary_to_decimal_ascii
`default_nettype none

package bda_pkg;

    localparam int BIN_WIDTH  = 32;
    localparam int NUM_CELLS  = 10;
    localparam int DIGIT_CAP  = 32;
    localparam logic [5:0] ASCII_ZERO = 6'd48;
    localparam logic [5:0] ASCII_NUL  = 6'd0;

    // one conversion request
    typedef struct packed {
        logic [31:0] number;
        logic [5:0]  min_digits;
    } req_t;

    // one result character
    typedef struct packed {
        logic [5:0] char_out;
        logic [5:0] digit_count;
        logic       last;
    } rsp_t;

    // control shared by every cell of the digit chain
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/bda_cell.sv
// one bcd digit cell of the double-dabble chain
// depends on bda_pkg for the control struct
`default_nettype none

module bda_cell (
    input  wire logic                clk,
    input  wire bda_pkg::cell_ctrl_t ctrl,
    input  wire logic                bit_in,
    input  wire logic [3:0]          digit_in,
    output logic      [3:0]          digit,
    output logic                     carry
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adjusted;

    // add three when the digit would overflow on doubling
    assign adjusted = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry    = adjusted[3];
    assign digit    = digit_reg;

    // clear, shift in one binary bit, or take the lower neighbour's digit
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

FILE: src/binary_to_decimal_ascii.sv
// 32-bit unsigned binary to decimal ascii converter, top level
// depends on bda_pkg, bda_cell and binary_to_decimal_ascii_defines.svh
// steps: a serial shift-add-3 conversion, a count step, alignment shifts when the
// request has fewer than 10 characters, then one character per cycle and a terminator,
// the terminator strobing in the cycle busy falls
// throughput: a new request is taken only once busy has fallen, set by the serial bcd chain
// reset: asynchronous active-low reset clears the controller and the strobe
`default_nettype none
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire bda_pkg::req_t request,
    output logic               busy,
    output logic               strobe,
    output bda_pkg::rsp_t      result
);

    localparam int NC = bda_pkg::NUM_CELLS;
    localparam logic [5:0] WANT_CAP =
        6'((MAX_DIGITS < bda_pkg::DIGIT_CAP) ? MAX_DIGITS : bda_pkg::DIGIT_CAP);
    localparam logic [5:0] NC_W = 6'(NC);

    typedef enum logic [2:0] {
        IDLE,
        CONV,
        COUNT,
        ALIGN,
        EMIT
    } state_t;

    state_t              state_reg;
    logic [31:0]         bin_reg;
    logic [4:0]          step_reg;
    logic [5:0]          want_reg;
    logic [5:0]          total_reg;
    logic [3:0]          skip_reg;
    logic [5:0]          remain_reg;
    logic                strobe_reg;
    bda_pkg::rsp_t       result_reg;

    bda_pkg::cell_ctrl_t ctrl;
    logic [3:0]          digits [NC];
    logic                carries [NC];
    logic [3:0]          nsig;
    logic [5:0]          total_calc;
    logic [3:0]          skip_calc;
    logic [5:0]          want_calc;
    logic                accept;

    assign accept = start && (state_reg == IDLE);
    assign busy   = (state_reg != IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // control for the digit chain
    always_comb
    begin
        ctrl.clear  = accept;
        ctrl.dabble = (state_reg == CONV);
        ctrl.shift  = (state_reg == ALIGN) ||
                      ((state_reg == EMIT) && (remain_reg != 6'd0) && (remain_reg <= NC_W));
    end

    // chain of bcd cells, least significant digit at index 0
    genvar g;
    generate
        for (g = 0; g < NC; g++)
        begin : g_cell
            logic       bit_in;
            logic [3:0] digit_in;
            if (g == 0)
            begin : g_first
                assign bit_in   = bin_reg[bda_pkg::BIN_WIDTH-1];
                assign digit_in = 4'd0;
            end
            else
            begin : g_rest
                assign bit_in   = carries[g-1];
                assign digit_in = digits[g-1];
            end
            bda_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .bit_in   (bit_in),
                .digit_in (digit_in),
                .digit    (digits[g]),
                .carry    (carries[g])
            );
        end
    endgenerate

    // number of significant digits, character total and alignment shifts
    always_comb
    begin
        nsig = 4'd0;
        for (int i = 0; i < NC; i++)
        begin
            if (digits[i] != 4'd0)
            begin
                nsig = 4'(i + 1);
            end
        end
        total_calc = (want_reg > {2'b00, nsig}) ? want_reg : {2'b00, nsig};
        skip_calc  = (total_calc >= NC_W) ? 4'd0 : 4'(NC_W - total_calc);
        want_calc  = (request.min_digits > WANT_CAP) ? WANT_CAP : request.min_digits;
    end

    // controller with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            strobe_reg <= 1'b0;
            bin_reg    <= '0;
            step_reg   <= '0;
            want_reg   <= '0;
            total_reg  <= '0;
            skip_reg   <= '0;
            remain_reg <= '0;
            result_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        bin_reg   <= request.number;
                        want_reg  <= want_calc;
                        step_reg  <= 5'(bda_pkg::BIN_WIDTH - 1);
                        state_reg <= CONV;
                    end
                end
                CONV:
                begin
                    bin_reg  <= {bin_reg[bda_pkg::BIN_WIDTH-2:0], 1'b0};
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= COUNT;
                    end
                end
                COUNT:
                begin
                    total_reg  <= total_calc;
                    remain_reg <= total_calc;
                    skip_reg   <= skip_calc;
                    state_reg  <= (skip_calc != 4'd0) ? ALIGN : EMIT;
                end
                ALIGN:
                begin
                    skip_reg <= skip_reg - 4'd1;
                    if (skip_reg == 4'd1)
                    begin
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    strobe_reg             <= 1'b1;
                    result_reg.digit_count <= total_reg;
                    if (remain_reg == 6'd0)
                    begin
                        result_reg.char_out <= bda_pkg::ASCII_NUL;
                        result_reg.last     <= 1'b1;
                        state_reg           <= IDLE;
                    end
                    else
                    begin
                        result_reg.last <= 1'b0;
                        remain_reg      <= remain_reg - 6'd1;
                        if (remain_reg > NC_W)
                        begin
                            result_reg.char_out <= bda_pkg::ASCII_ZERO;
                        end
                        else
                        begin
                            result_reg.char_out <= bda_pkg::ASCII_ZERO + {2'b00, digits[NC-1]};
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // terminator only leaves as the controller returns to idle
    `BDA_ASSERT_IMPLY(a_last_idle, strobe_reg && result_reg.last, state_reg == IDLE, "terminator while busy")
    // every character carries the total of its request
    `BDA_ASSERT_IMPLY(a_count_match, strobe_reg, result_reg.digit_count == total_reg, "digit count mismatch")
    // digit characters are ascii decimal digits
    `BDA_ASSERT_IMPLY(a_digit_ascii, strobe_reg && !result_reg.last, (result_reg.char_out >= bda_pkg::ASCII_ZERO) && (result_reg.char_out <= 6'd57), "non-digit character")
    // no character leaves during conversion
    `BDA_ASSERT_IMPLY(a_quiet_conv, state_reg == CONV || state_reg == COUNT, !strobe_reg, "strobe during conversion")

endmodule

`default_nettype wire
